@@ hdl/point_frame_deframer_unit_assert.svh @@
// Assertion macros for the point frame deframer.
// Included by the top level; depends on nothing else.
`ifndef POINT_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define POINT_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point frame deframer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point frame deframer: next-cycle check failed");

`endif

@@ hdl/pfd_pkg.sv @@
// Package for the point frame deframer: phase and status codes, result struct,
// frame constants and small helper functions. Depends on nothing.
package pfd_pkg;

    // Frame layout constants.
    localparam int MAGIC_LEN  = 10;
    localparam int HEADER_LEN = 18;
    localparam int PT_BYTES   = 12;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BAD_MAGIC,
        STAT_BAD_LENGTH,
        STAT_TRUNCATED
    } status_t;

    // One result item.
    typedef struct packed {
        logic        point_valid;
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic        frame_end;
        status_t     status;
    } result_t;

    // Expected magic byte at each header position ("POINTCLOUD").
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h50; // P
            4'd1:    b = 8'h4F; // O
            4'd2:    b = 8'h49; // I
            4'd3:    b = 8'h4E; // N
            4'd4:    b = 8'h54; // T
            4'd5:    b = 8'h43; // C
            4'd6:    b = 8'h4C; // L
            4'd7:    b = 8'h4F; // O
            4'd8:    b = 8'h55; // U
            4'd9:    b = 8'h44; // D
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Reduces a value below 1536 modulo 12 by conditional subtraction.
    function automatic logic [3:0] mod12(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        for (int j = 6; j >= 0; j--) begin
            if (r >= (11'd12 << j))
            begin
                r = r - (11'd12 << j);
            end
        end
        return r[3:0];
    endfunction

    // True when the exponent field of a single float is all ones.
    function automatic logic exp_ones(input logic [31:0] v);
        return v[30:23] == 8'hFF;
    endfunction

endpackage

@@ hdl/pfd_byte_if.sv @@
// Byte stream channel of the point frame deframer.
// Carries valid, ready, the data byte and the end-of-stream mark.
interface pfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ hdl/pfd_point_if.sv @@
// Result channel of the point frame deframer.
// Carries valid, ready, the point coordinates, frame end and status.
interface pfd_point_if;
    logic        valid;
    logic        ready;
    logic        point_valid;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] z_bits;
    logic        frame_end;
    logic [1:0]  status;

    modport source (output valid, output point_valid, output x_bits, output y_bits,
                    output z_bits, output frame_end, output status, input ready);
    modport sink   (input valid, input point_valid, input x_bits, input y_bits,
                    input z_bits, input frame_end, input status, output ready);
endinterface

@@ hdl/pfd_parser.sv @@
// Frame parser of the point frame deframer: header check, length capture and
// point assembly, one byte per cycle while a byte is accepted. Depends on pfd_pkg.
module pfd_parser #(
    parameter int LENGTH_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        data_byte,
    input  logic              stream_end,
    output logic              res_valid,
    output pfd_pkg::result_t  res
);
    import pfd_pkg::*;

    // Largest multiple of 12 that fits the length register.
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_SAT =
        LEN_MAX - (LEN_MAX % LENGTH_BITS'(PT_BYTES));

    phase_t                 phase_reg, phase_next;
    logic [4:0]             hdr_idx_reg, hdr_idx_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic                   ovf_reg, ovf_next;
    logic [3:0]             residue_reg, residue_next;
    logic [3:0]             pt_idx_reg, pt_idx_next;
    logic [31:0]            x_reg, x_next;
    logic [31:0]            y_reg, y_next;
    logic [23:0]            zp_reg, zp_next;

    logic                   in_magic;
    logic                   magic_hit;
    logic                   hdr_last;
    logic [2:0]             len_k;
    logic [63:0]            len_wide;
    logic [LENGTH_BITS-1:0] rem_build;
    logic                   ovf_build;
    logic [10:0]            residue_sum;
    logic [3:0]             residue_new;
    logic                   pt_done;
    logic [31:0]            z_full;
    logic                   pt_kept;
    logic                   rem_last;

    // Header decode: magic compare and length byte placement.
    assign in_magic    = hdr_idx_reg < 5'(MAGIC_LEN);
    assign magic_hit   = data_byte == magic_byte(hdr_idx_reg[3:0]);
    assign hdr_last    = hdr_idx_reg == 5'(HEADER_LEN - 1);
    assign len_k       = 3'(hdr_idx_reg - 5'(MAGIC_LEN));
    assign len_wide    = 64'(data_byte) << {len_k, 3'b000};
    assign rem_build   = rem_reg | len_wide[LENGTH_BITS-1:0];
    assign ovf_build   = ovf_reg | (|(len_wide >> LENGTH_BITS));

    // Length modulo 12: byte 0 weighs 1, every higher byte weighs 4.
    assign residue_sum = 11'(residue_reg) +
                         ((len_k == 3'd0) ? 11'(data_byte) : {1'b0, data_byte, 2'b00});
    assign residue_new = mod12(residue_sum);

    // Payload decode: point completion and finiteness test.
    assign pt_done  = pt_idx_reg == 4'(PT_BYTES - 1);
    assign z_full   = {data_byte, zp_reg};
    assign pt_kept  = pt_done && !exp_ones(x_reg) && !exp_ones(y_reg) && !exp_ones(z_full);
    assign rem_last = rem_reg == LENGTH_BITS'(1);

    // Next state of the parser.
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        rem_next     = rem_reg;
        ovf_next     = ovf_reg;
        residue_next = residue_reg;
        pt_idx_next  = pt_idx_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        zp_next      = zp_reg;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (in_magic)
                begin
                    if (!magic_hit)
                    begin
                        phase_next   = PH_HALT;
                        hdr_idx_next = '0;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 5'd1;
                    end
                end
                else
                begin
                    rem_next     = rem_build;
                    ovf_next     = ovf_build;
                    residue_next = residue_new;
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                    if (hdr_last)
                    begin
                        hdr_idx_next = '0;
                        residue_next = '0;
                        ovf_next     = 1'b0;
                        if (residue_new != 4'd0)
                        begin
                            phase_next = PH_HALT;
                            rem_next   = '0;
                        end
                        else if (rem_build != '0 || ovf_build)
                        begin
                            phase_next  = PH_PAYLOAD;
                            pt_idx_next = '0;
                            rem_next    = ovf_build ? LEN_SAT : rem_build;
                        end
                        else
                        begin
                            rem_next = '0;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // Little-endian assembly of x, y and the low 24 bits of z.
                if (pt_idx_reg < 4'd4)
                begin
                    if (pt_idx_reg == 4'd0)
                    begin
                        x_next = {24'd0, data_byte};
                    end
                    else
                    begin
                        x_next[8*pt_idx_reg[1:0] +: 8] = data_byte;
                    end
                end
                else if (pt_idx_reg < 4'd8)
                begin
                    if (pt_idx_reg == 4'd4)
                    begin
                        y_next = {24'd0, data_byte};
                    end
                    else
                    begin
                        y_next[8*pt_idx_reg[1:0] +: 8] = data_byte;
                    end
                end
                else if (!pt_done)
                begin
                    if (pt_idx_reg == 4'd8)
                    begin
                        zp_next = {16'd0, data_byte};
                    end
                    else
                    begin
                        zp_next[8*pt_idx_reg[1:0] +: 8] = data_byte;
                    end
                end
                pt_idx_next = pt_done ? 4'd0 : pt_idx_reg + 4'd1;
                rem_next    = rem_reg - LENGTH_BITS'(1);
                if (rem_last)
                begin
                    phase_next  = PH_SEARCH;
                    pt_idx_next = '0;
                end
            end
            default:
            begin
                // Halted: bytes are dropped until the end of the stream.
            end
        endcase

        // The last byte of the stream returns everything to header search.
        if (stream_end)
        begin
            phase_next   = PH_SEARCH;
            hdr_idx_next = '0;
            rem_next     = '0;
            ovf_next     = 1'b0;
            residue_next = '0;
            pt_idx_next  = '0;
            x_next       = '0;
            y_next       = '0;
            zp_next      = '0;
        end
    end

    // Result item produced by the byte being accepted.
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (in_magic && !magic_hit)
                begin
                    res_valid  = in_fire;
                    res.status = STAT_BAD_MAGIC;
                end
                else if (!in_magic && hdr_last && residue_new != 4'd0)
                begin
                    res_valid  = in_fire;
                    res.status = STAT_BAD_LENGTH;
                end
            end
            PH_PAYLOAD:
            begin
                res.point_valid = pt_kept;
                res.x_bits      = pt_kept ? x_reg  : 32'd0;
                res.y_bits      = pt_kept ? y_reg  : 32'd0;
                res.z_bits      = pt_kept ? z_full : 32'd0;
                res.frame_end   = rem_last || stream_end;
                res.status      = (!rem_last && stream_end) ? STAT_TRUNCATED : STAT_OK;
                res_valid       = in_fire && (pt_kept || rem_last || stream_end);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SEARCH;
            hdr_idx_reg <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
            residue_reg <= '0;
            pt_idx_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            residue_reg <= residue_next;
            pt_idx_reg  <= pt_idx_next;
        end
    end

    // Coordinate holding registers; each is rewritten before it is read.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            zp_reg <= zp_next;
        end
    end

endmodule

@@ hdl/pfd_skid.sv @@
// Output register with a skid stage for the point frame deframer results.
// Keeps the input ready free of any path from the output ready. Depends on pfd_pkg.
module pfd_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  pfd_pkg::result_t res,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output pfd_pkg::result_t out_res
);
    import pfd_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // Move items between the skid stage and the output register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

@@ hdl/point_frame_deframer_unit.sv @@
// Top level of the point frame deframer.
// Depends on pfd_pkg, pfd_byte_if, pfd_point_if, pfd_parser, pfd_skid and the assert header.
//
// Usage:
//   stream carries one byte per item with a stream_end mark on the last byte of
//   the stream. Frames are "POINTCLOUD", a 64-bit little-endian byte length, and
//   12-byte points of three little-endian single floats.
//   points carries at most one result item per byte: a finite point, a frame end
//   mark, or a status code for a bad magic, a bad length or a truncated payload.
//   Throughput is one byte per clock while stream.ready is high; the parser updates its
//   state in the cycle a byte is accepted. A result reaches points through the output
//   register or the skid stage. After a header error the block drops bytes until stream_end.
//   Reset clears the parser to header search and empties the output stage.
//   When points stalls, one result waits in the output register and one more in
//   a skid stage; stream.ready falls only while the skid stage holds an item.
//   LENGTH_BITS sets the width of the payload length counter; longer lengths
//   saturate to the largest multiple of 12 that fits.
module point_frame_deframer_unit #(
    parameter int LENGTH_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    pfd_byte_if.sink   stream,
    pfd_point_if.source points
);
    import pfd_pkg::*;

    `include "point_frame_deframer_unit_assert.svh"

    logic    in_fire;
    logic    in_ready;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign stream.ready = in_ready;
    assign in_fire      = stream.valid && in_ready;

    // Byte parser.
    pfd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .data_byte (stream.data_byte),
        .stream_end(stream.stream_end),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffering.
    pfd_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_valid(res_valid),
        .res      (res),
        .in_ready (in_ready),
        .out_valid(points.valid),
        .out_ready(points.ready),
        .out_res  (out_res)
    );

    // Result fields onto the channel.
    assign points.point_valid = out_res.point_valid;
    assign points.x_bits      = out_res.x_bits;
    assign points.y_bits      = out_res.y_bits;
    assign points.z_bits      = out_res.z_bits;
    assign points.frame_end   = out_res.frame_end;
    assign points.status      = out_res.status;

    // A full skid stage always sits behind a valid output.
    `PFD_ASSERT_SAME(a_skid_behind_output, clk, rst_n, !stream.ready, points.valid)

    // A result without a point is either a frame end or an error.
    `PFD_ASSERT_SAME(a_empty_result_meaning, clk, rst_n, points.valid && !points.point_valid, points.frame_end || (points.status != STAT_OK))

    // A new result during a stall lands in the skid stage and closes the input.
    `PFD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, points.valid && !points.ready && res_valid, !stream.ready)

endmodule

@@ tb/sv/point_frame_deframer_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for point_frame_deframer_unit: a short directed table, then
// random framed byte streams checked against a behavioral deframer kept in this file.
// Depends on pfd_pkg, pfd_byte_if, pfd_point_if and the RTL of the block.
module point_frame_deframer_unit_tb;
    import pfd_pkg::*;

    localparam int LEN_BITS = 64;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [79:0] MAGIC_TEXT = "POINTCLOUD";

    // How a table row gets its expectation: from the predictor, none, or typed in.
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_QUIET,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        row_kind_t  kind;
        result_t    typed;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } plan_byte_t;

    localparam result_t R_NONE = '0;
    localparam result_t R_BAD_MAGIC = '{point_valid: 1'b0, x_bits: '0, y_bits: '0,
                                        z_bits: '0, frame_end: 1'b0,
                                        status: STAT_BAD_MAGIC};
    localparam result_t R_DROPPED = '{point_valid: 1'b0, x_bits: '0, y_bits: '0,
                                      z_bits: '0, frame_end: 1'b1, status: STAT_OK};

    // Directed rows: a bad magic that also ends the stream, then a frame of one point
    // whose x is infinite, so the only result is a bare frame end.
    localparam dir_row_t DIRECTED_ROWS [31] = '{
        '{8'h00, 1'b1, ROW_RESULT, R_BAD_MAGIC},
        '{8'h50, 1'b0, ROW_QUIET, R_NONE},
        '{8'h4F, 1'b0, ROW_QUIET, R_NONE},
        '{8'h49, 1'b0, ROW_QUIET, R_NONE},
        '{8'h4E, 1'b0, ROW_QUIET, R_NONE},
        '{8'h54, 1'b0, ROW_QUIET, R_NONE},
        '{8'h43, 1'b0, ROW_QUIET, R_NONE},
        '{8'h4C, 1'b0, ROW_QUIET, R_NONE},
        '{8'h4F, 1'b0, ROW_QUIET, R_NONE},
        '{8'h55, 1'b0, ROW_QUIET, R_NONE},
        '{8'h44, 1'b0, ROW_QUIET, R_NONE},
        '{8'h0C, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h80, 1'b0, ROW_QUIET, R_NONE},
        '{8'h7F, 1'b0, ROW_QUIET, R_NONE},
        '{8'hFF, 1'b0, ROW_QUIET, R_NONE},
        '{8'hFF, 1'b0, ROW_QUIET, R_NONE},
        '{8'hFF, 1'b0, ROW_QUIET, R_NONE},
        '{8'hFF, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_QUIET, R_NONE},
        '{8'h00, 1'b0, ROW_RESULT, R_DROPPED}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pfd_byte_if  byte_ch ();
    pfd_point_if point_ch ();

    point_frame_deframer_unit #(
        .LENGTH_BITS(LEN_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .stream(byte_ch),
        .points(point_ch)
    );

    // Deframer state as the checker sees it.
    phase_t      dfm_phase;
    logic [4:0]  dfm_hdr_pos;
    logic [63:0] dfm_left;
    logic [3:0]  dfm_residue;
    logic [3:0]  dfm_pt_pos;
    logic [31:0] dfm_x;
    logic [31:0] dfm_y;
    logic [23:0] dfm_z_low;

    result_t     expected_points[$];
    plan_byte_t  byte_plan[$];
    row_kind_t   drv_kind = ROW_MODEL;
    result_t     drv_typed = '0;
    int          burst_left = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic [9:0]  sink_cycle = '0;

    always #5 clk = ~clk;

    function automatic logic [7:0] magic_at(input int pos);
        return MAGIC_TEXT[79 - 8 * pos -: 8];
    endfunction

    function automatic logic exp_saturated(input logic [31:0] v);
        return v[30:23] == 8'hFF;
    endfunction

    function automatic void clear_deframer();
        dfm_phase   = PH_SEARCH;
        dfm_hdr_pos = '0;
        dfm_left    = '0;
        dfm_residue = '0;
        dfm_pt_pos  = '0;
        dfm_x       = '0;
        dfm_y       = '0;
        dfm_z_low   = '0;
    endfunction

    // Advances the deframer by one byte and reports the result it gives, if any.
    function automatic void deframe_byte(input logic [7:0] b, input logic last,
                                         output logic hit, output result_t res);
        logic [63:0] len_cap;
        int          k;
        logic [31:0] z_word;
        logic        done;
        logic        keep;
        len_cap = {64{1'b1}} >> (64 - LEN_BITS);
        hit = 1'b0;
        res = '0;
        done = 1'b0;
        keep = 1'b0;
        z_word = '0;
        case (dfm_phase)
            PH_SEARCH:
            begin
                if (dfm_hdr_pos < MAGIC_LEN)
                begin
                    if (b != magic_at(dfm_hdr_pos))
                    begin
                        res.status = STAT_BAD_MAGIC;
                        hit = 1'b1;
                        dfm_phase = PH_HALT;
                        dfm_hdr_pos = '0;
                    end
                    else
                    begin
                        dfm_hdr_pos++;
                    end
                end
                else
                begin
                    // Length bytes: 256^k is 4 mod 12 for every k above zero.
                    k = (int'(dfm_hdr_pos) - MAGIC_LEN) & 7;
                    dfm_left |= 64'(b) << (8 * k);
                    dfm_residue = 4'((int'(dfm_residue) + int'(b) * (k == 0 ? 1 : 4)) % 12);
                    dfm_hdr_pos++;
                    if (dfm_hdr_pos >= HEADER_LEN)
                    begin
                        dfm_hdr_pos = '0;
                        if (dfm_residue != 0)
                        begin
                            res.status = STAT_BAD_LENGTH;
                            hit = 1'b1;
                            dfm_phase = PH_HALT;
                        end
                        else if (dfm_left != 0)
                        begin
                            if (dfm_left > len_cap)
                            begin
                                dfm_left = len_cap - len_cap % 12;
                            end
                            dfm_phase = PH_PAYLOAD;
                            dfm_pt_pos = '0;
                        end
                        dfm_residue = '0;
                        if (dfm_phase != PH_PAYLOAD)
                        begin
                            dfm_left = '0;
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // Gather the little-endian coordinates of the current point.
                if (dfm_pt_pos < 4)
                begin
                    dfm_x = (dfm_pt_pos == 0) ? 32'(b) : (dfm_x | (32'(b) << (8 * dfm_pt_pos)));
                end
                else if (dfm_pt_pos < 8)
                begin
                    dfm_y = (dfm_pt_pos == 4) ? 32'(b)
                                              : (dfm_y | (32'(b) << (8 * (dfm_pt_pos - 4))));
                end
                else if (dfm_pt_pos < 11)
                begin
                    dfm_z_low = (dfm_pt_pos == 8) ? 24'(b)
                                                  : (dfm_z_low | (24'(b) << (8 * (dfm_pt_pos - 8))));
                end
                else
                begin
                    z_word = {b, dfm_z_low};
                    done = 1'b1;
                    keep = !exp_saturated(dfm_x) && !exp_saturated(dfm_y)
                           && !exp_saturated(z_word);
                end
                dfm_pt_pos = done ? 4'd0 : dfm_pt_pos + 4'd1;
                dfm_left--;
                if (done && keep)
                begin
                    res.point_valid = 1'b1;
                    res.x_bits = dfm_x;
                    res.y_bits = dfm_y;
                    res.z_bits = z_word;
                end
                if (dfm_left == 0)
                begin
                    res.frame_end = 1'b1;
                    hit = 1'b1;
                    dfm_phase = PH_SEARCH;
                    dfm_pt_pos = '0;
                end
                else if (last)
                begin
                    res.frame_end = 1'b1;
                    res.status = STAT_TRUNCATED;
                    hit = 1'b1;
                end
                else if (done && keep)
                begin
                    hit = 1'b1;
                end
                if (!hit)
                begin
                    res = '0;
                end
            end
            default:
            begin
                // Halted: bytes are dropped until the end of the stream.
            end
        endcase
        if (last)
        begin
            clear_deframer();
        end
    endfunction

    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v = 32'h0000_0000;
            2: v = 32'hFFFF_FFFF;
            3: v[30:23] = 8'hFE;
            default: ;
        endcase
        return v;
    endfunction

    function automatic void plan_byte(input logic [7:0] b);
        plan_byte_t entry;
        entry.data = b;
        entry.last = 1'b0;
        byte_plan = {byte_plan, entry};
    endfunction

    function automatic void mark_end();
        byte_plan[byte_plan.size() - 1].last = 1'b1;
    endfunction

    // Emits the first count bytes of a header that carries the given length.
    function automatic void plan_header(input logic [63:0] len, input int count);
        for (int i = 0; i < count; i++)
        begin
            plan_byte(i < MAGIC_LEN ? magic_at(i) : len[8 * (i - MAGIC_LEN) +: 8]);
        end
    endfunction

    function automatic void plan_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
        begin
            plan_byte(w[8 * i +: 8]);
        end
    endfunction

    // Bytes the block drops after a header error, then the end of the stream.
    function automatic void plan_halted_tail();
        repeat ($urandom_range(0, 4)) plan_byte(8'($urandom_range(0, 255)));
        mark_end();
    endfunction

    // Random stream: mostly whole frames, plus truncations, header errors and noise.
    function automatic void plan_stream(input int target);
        int          counted;
        int          pick;
        int          npts;
        int          cut;
        int          pos;
        logic [63:0] len;
        logic [7:0]  b;
        counted = 0;
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                npts = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                plan_header(64'(PT_BYTES * npts), HEADER_LEN);
                repeat (3 * npts) plan_word(random_coord());
                if ($urandom_range(0, 4) == 0)
                begin
                    mark_end();
                end
                counted += HEADER_LEN + PT_BYTES * npts;
            end
            else if (pick < 70)
            begin
                // The stream ends before the payload does.
                npts = $urandom_range(0, 2);
                if ($urandom_range(0, 2) == 0)
                begin
                    len = {$urandom, $urandom};
                    len[63] = 1'b1;
                    len -= len % 12;
                end
                else
                begin
                    len = 64'(PT_BYTES * (npts + $urandom_range(1, 3)));
                end
                cut = $urandom_range(0, PT_BYTES * npts + 11);
                plan_header(len, HEADER_LEN);
                repeat (cut) plan_byte(8'($urandom_range(0, 255)));
                mark_end();
                counted += HEADER_LEN + cut;
            end
            else if (pick < 80)
            begin
                len = $urandom_range(0, 1) ? 64'($urandom_range(1, 400)) : {$urandom, $urandom};
                if (len % 12 == 0)
                begin
                    len += 1;
                end
                plan_header(len, HEADER_LEN);
                plan_halted_tail();
                counted += HEADER_LEN;
            end
            else if (pick < 90)
            begin
                pos = $urandom_range(0, MAGIC_LEN - 1);
                plan_header('0, pos);
                b = 8'($urandom_range(0, 255));
                if (b == magic_at(pos))
                begin
                    b ^= 8'h01 << $urandom_range(0, 7);
                end
                plan_byte(b);
                plan_halted_tail();
                counted += pos + 1;
            end
            else if (pick < 95)
            begin
                cut = $urandom_range(1, HEADER_LEN - 1);
                plan_header({$urandom, $urandom}, cut);
                mark_end();
                counted += cut;
            end
            else
            begin
                cut = $urandom_range(1, 8);
                repeat (cut) plan_byte(8'($urandom_range(0, 255)));
                mark_end();
                counted += cut;
            end
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_byte(input logic [7:0] data, input logic last,
                             input row_kind_t kind, input result_t typed);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.data_byte  <= data;
        byte_ch.stream_end <= last;
        drv_kind           <= kind;
        drv_typed          <= typed;
        @(posedge clk);
        while (!byte_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t mismatch, %s: expected pv=%0d x=%h y=%h z=%h end=%0d code=%0d",
                     $time, what, want.point_valid, want.x_bits, want.y_bits, want.z_bits,
                     want.frame_end, want.status);
            $display("%0t            got pv=%0d x=%h y=%h z=%h end=%0d code=%0d",
                     $time, got.point_valid, got.x_bits, got.y_bits, got.z_bits,
                     got.frame_end, got.status);
        end
    endtask

    // Every accepted byte advances the deframer and may queue an expected point.
    always @(posedge clk)
    begin : predict_side
        logic    hit;
        result_t res;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            deframe_byte(byte_ch.data_byte, byte_ch.stream_end, hit, res);
            if (drv_kind == ROW_RESULT)
            begin
                expected_points = {expected_points, drv_typed};
            end
            else if (drv_kind == ROW_MODEL && hit)
            begin
                expected_points = {expected_points, res};
            end
        end
    end

    // Every accepted result is matched against the oldest expected point.
    always @(posedge clk)
    begin : check_side
        result_t got;
        result_t want;
        if (rst_n && point_ch.valid && point_ch.ready)
        begin
            got.point_valid = point_ch.point_valid;
            got.x_bits      = point_ch.x_bits;
            got.y_bits      = point_ch.y_bits;
            got.z_bits      = point_ch.z_bits;
            got.frame_end   = point_ch.frame_end;
            got.status      = status_t'(point_ch.status);
            if (expected_points.size() == 0)
            begin
                report_mismatch("nothing pending", '0, got);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    report_mismatch("wrong fields", want, got);
                end
            end
        end
    end

    // Receiver stalls: always ready, light random, long periodic, then coin flips.
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 10'd1;
        case (sink_cycle[9:8])
            2'd0:    point_ch.ready <= 1'b1;
            2'd1:    point_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    point_ch.ready <= (sink_cycle[2:0] == 3'd0);
            default: point_ch.ready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = '0;
        byte_ch.stream_end = 1'b0;
        point_ch.ready     = 1'b0;
        clear_deframer();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table.
        foreach (DIRECTED_ROWS[i])
        begin
            send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last,
                      DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].typed);
        end

        // Random streams.
        plan_stream(RANDOM_BYTES);
        while (byte_plan.size() != 0)
        begin
            plan_byte_t pb;
            pb = byte_plan.pop_front();
            send_byte(pb.data, pb.last, ROW_MODEL, R_NONE);
        end
        byte_ch.valid <= 1'b0;

        // Drain: wait for the last results, then a few quiet cycles.
        @(posedge clk);
        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_points.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
